### rtl/cgil_pkg.sv
// ----------------------------------------------------------------------------
// cgil_pkg
// Shared types and constants for the glyph coverage index lookup block.
// ----------------------------------------------------------------------------
package cgil_pkg;

    // Field widths fixed by the item format.
    localparam int GLYPH_W   = 16;
    localparam int INDEX_W   = 10;
    localparam int COUNT_W   = 11;
    localparam int FORMAT_W  = 2;
    localparam int COV_W     = 17;
    localparam int CFG_IDX_W = 2;

    // Item function codes.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Table formats.
    localparam logic [FORMAT_W-1:0] FMT_SINGLE = 2'd1;
    localparam logic [FORMAT_W-1:0] FMT_RANGE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd1;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [GLYPH_W-1:0] first;
        logic [GLYPH_W-1:0] last;
        logic [GLYPH_W-1:0] start;
    } entry_t;

    // One lookup result.
    typedef struct packed {
        logic             found;
        logic [COV_W-1:0] index;
    } result_t;

endpackage

### rtl/glyph_coverage_index_lookup_top.sv
// ----------------------------------------------------------------------------
// glyph_coverage_index_lookup_top
// Coverage table lookup: load items fill a sorted entry table, lookup items
// are answered by a binary search over the first entry_count entries.
//
// Usage:
//   Input channel (in_valid/in_ready): func selects a load (write one table
//   entry at entry_index) or a lookup of lookup_glyph. A load gives no
//   result. A lookup gives one result on the output
//   channel (out_valid/out_ready): found and coverage_index.
//   Configuration channel (cfg_valid/cfg_ready): register 0 is table_format,
//   register 1 is entry_count. Writes are taken in any cycle and must only
//   be issued while the block is idle.
//   Lookup sequence: the first read is issued as the item is accepted,
//   then each returned entry is compared and the next probe is read
//   (at most 11 probes for 1024 entries, about log2(entry_count)+1), and
//   the result then moves to the output register. The probe loop runs
//   through the single read port, so items are handled one at a time.
//   Unknown formats and an empty table finish without a table read.
//   The next item is accepted once the result has moved to the output
//   register; if the receiver stalls and the output register is full, the
//   finished result waits in the search unit and no new item is accepted.
//   Reset: table_format = 1, entry_count = 0, no result pending. The table
//   contents are undefined until written.
// ----------------------------------------------------------------------------
module glyph_coverage_index_lookup_top
    import cgil_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [INDEX_W-1:0]   entry_index,
    input  logic [GLYPH_W-1:0]   entry_first_glyph,
    input  logic [GLYPH_W-1:0]   entry_last_glyph,
    input  logic [GLYPH_W-1:0]   entry_start_index,
    input  logic [GLYPH_W-1:0]   lookup_glyph,
    // Output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 found,
    output logic [COV_W-1:0]     coverage_index
);

    // Only entry indexes below 2**INDEX_W can ever be written.
    localparam int MEM_DEPTH = (TABLE_DEPTH < (1 << INDEX_W)) ?
                               TABLE_DEPTH : (1 << INDEX_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        COUNT_W'((TABLE_DEPTH < COUNT_MAX) ? TABLE_DEPTH : COUNT_MAX);
    localparam logic [INDEX_W:0] WRITE_LIMIT = (INDEX_W+1)'(MEM_DEPTH);

    logic [FORMAT_W-1:0] format_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_eff;

    logic                out_valid_reg;
    result_t             out_res_reg;

    logic                in_xfer;
    logic                slot_free;
    logic                search_idle;
    logic                wr_en;
    entry_t              wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    entry_t              rd_data;
    logic                res_valid;
    result_t             res;

    // Configuration register writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_SINGLE;
            count_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FORMAT: format_reg <= cfg_data[FORMAT_W-1:0];
                REG_COUNT:  count_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Searched entry count is capped at the table depth.
    assign count_eff = (count_reg > COUNT_LIMIT) ? COUNT_LIMIT : count_reg;

    // Input transfer and table load.
    assign in_ready  = search_idle;
    assign in_xfer   = in_valid && in_ready;
    assign wr_en     = in_xfer && (func == FUNC_LOAD) &&
                       ({1'b0, entry_index} < WRITE_LIMIT);
    assign wr_data   = '{first: entry_first_glyph, last: entry_last_glyph,
                         start: entry_start_index};

    cgil_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_index[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cgil_search #(
        .ADDR_W (ADDR_W)
    ) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_xfer && (func == FUNC_LOOKUP)),
        .glyph        (lookup_glyph),
        .table_format (format_reg),
        .count        (count_eff),
        .rd_data      (rd_data),
        .slot_free    (slot_free),
        .idle         (search_idle),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Output register: takes a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = out_res_reg.found;
    assign coverage_index = out_res_reg.index;

endmodule

### rtl/cgil_mem.sv
// ----------------------------------------------------------------------------
// cgil_mem
// Entry table storage: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module cgil_mem
    import cgil_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered output.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/cgil_search.sv
// ----------------------------------------------------------------------------
// cgil_search
// Binary search sequencer. Issues one table read per cycle, compares the
// returned entry against the glyph and narrows the [lo, hi) window.
// ----------------------------------------------------------------------------
module cgil_search
    import cgil_pkg::*;
#(
    parameter int ADDR_W = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [GLYPH_W-1:0]  glyph,
    input  logic [FORMAT_W-1:0] table_format,
    input  logic [COUNT_W-1:0]  count,
    input  entry_t              rd_data,
    input  logic                slot_free,
    output logic                idle,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    output logic                res_valid,
    output result_t             res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] lo_reg, lo_next;
    logic [COUNT_W-1:0] hi_reg, hi_next;
    logic [COUNT_W-1:0] mid_reg, mid_next;
    logic [GLYPH_W-1:0] glyph_reg, glyph_next;
    result_t            res_reg, res_next;

    logic               fmt_ok;
    logic               below;
    logic               above;
    logic [GLYPH_W-1:0] high_edge;
    logic [COUNT_W-1:0] lo_cmp;
    logic [COUNT_W-1:0] hi_cmp;
    logic [COUNT_W:0]   mid_sum;
    logic [COV_W-1:0]   range_index;

    // Entry comparison for the probe whose data has just returned. A glyph
    // below the entry takes priority, so a reversed range only moves hi.
    always_comb
    begin
        fmt_ok      = (table_format == FMT_SINGLE) || (table_format == FMT_RANGE);
        high_edge   = (table_format == FMT_SINGLE) ? rd_data.first : rd_data.last;
        below       = glyph_reg < rd_data.first;
        above       = glyph_reg > high_edge;
        lo_cmp      = (above && !below) ? (mid_reg + 1'b1) : lo_reg;
        hi_cmp      = below ? mid_reg : hi_reg;
        mid_sum     = {1'b0, lo_cmp} + {1'b0, hi_cmp};
        range_index = {1'b0, rd_data.start} + {1'b0, glyph_reg - rd_data.first};
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        glyph_next = glyph_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    glyph_next = glyph;
                    lo_next    = '0;
                    hi_next    = count;
                    mid_next   = {1'b0, count[COUNT_W-1:1]};
                    res_next   = '0;
                    if (fmt_ok && (count != '0))
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CMP:
            begin
                if (!below && !above)
                begin
                    res_next.found = 1'b1;
                    res_next.index = (table_format == FMT_SINGLE) ?
                                     COV_W'(mid_reg) : range_index;
                    state_next     = ST_DONE;
                end
                else
                begin
                    lo_next  = lo_cmp;
                    hi_next  = hi_cmp;
                    mid_next = mid_sum[COUNT_W:1];
                    if (lo_cmp < hi_cmp)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Search window and result.
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        glyph_reg <= glyph_next;
        res_reg   <= res_next;
    end

    assign idle    = (state_reg == ST_IDLE);
    assign rd_addr = mid_next[ADDR_W-1:0];
    assign res     = res_reg;

endmodule
